@@ design/fscl_pkg.sv @@
// ----------------------------------------------------------------------------
// fscl_pkg: shared types and constants of the serial configuration loader
// Item codes, status codes, register indexes and the command word that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
package fscl_pkg;

  // field widths fixed by the item format
  localparam int unsigned LimitWidth   = 16;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned BitIdxWidth  = $clog2(ByteWidth);

  // defaults for the top level parameters
  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned QueueDepthDef = 2;

  // reset values of the limit registers
  localparam logic [LimitWidth-1:0] InitLimitReset = LimitWidth'(10000);
  localparam logic [LimitWidth-1:0] DoneLimitReset = LimitWidth'(1000);

  // configuration register indexes
  localparam logic RegInitLimit = 1'b0;
  localparam logic RegDoneLimit = 1'b1;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_END   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_WORKING       = 3'd0,
    ST_DONE          = 3'd1,
    ST_INIT_NOT_LOW  = 3'd2,
    ST_INIT_NOT_HIGH = 3'd3,
    ST_CONFIG_ERROR  = 3'd4,
    ST_DONE_TIMEOUT  = 3'd5,
    ST_IGNORED       = 3'd6
  } status_e;

  // one queued command: either a single result or a byte to shift out
  typedef struct packed {
    logic                 is_byte;
    logic                 prog;
    logic                 data;
    logic                 clk;
    status_e              status;
    logic [ByteWidth-1:0] byte_val;
  } cmd_t;

endpackage

@@ design/fscl_front.sv @@
// ----------------------------------------------------------------------------
// fscl_front: sequence state and item classification
// Holds the configuration phase, poll counter, pin levels and limit
// registers; turns each accepted item into one command for the back part.
// ----------------------------------------------------------------------------
module fscl_front import fscl_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [LimitWidth-1:0] cfg_data_i,
  // accepted item
  input  logic                  item_vld_i,
  input  action_e               action_i,
  input  logic [ByteWidth-1:0]  data_byte_i,
  input  logic                  done_pin_i,
  input  logic                  init_pin_i,
  // command toward the queue
  output cmd_t                  cmd_o
);

  localparam int unsigned CmpWidth = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CHECK_INIT = 3'd1,
    PH_WAIT_INIT  = 3'd2,
    PH_LOADING    = 3'd3,
    PH_WAIT_DONE  = 3'd4,
    PH_FINISHED   = 3'd5,
    PH_FAILED     = 3'd6
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  prog_q, prog_d;
  logic                  data_q, data_d;
  logic [LimitWidth-1:0] init_limit_q, done_limit_q;

  logic [CountWidth-1:0] count_inc;
  logic [CountWidth-1:0] done_src;
  logic                  init_over;
  logic                  done_over;
  status_e               status;
  logic                  clk_pulse;
  logic                  is_byte;

  // saturating increment and timeout compares
  assign count_inc = (count_q == '1) ? count_q : count_q + CountWidth'(1);
  assign init_over = CmpWidth'(count_q) > CmpWidth'(init_limit_q);
  // an end item starts the done wait with a cleared count
  assign done_src  = (action_i == ACT_END) ? '0 : count_q;
  assign done_over = CmpWidth'(done_src) > CmpWidth'(done_limit_q);

  // next state and command
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    prog_d    = prog_q;
    data_d    = data_q;
    status    = ST_IGNORED;
    clk_pulse = 1'b0;
    is_byte   = 1'b0;
    unique case (action_i)
      ACT_START: begin
        prog_d  = 1'b0;
        count_d = '0;
        phase_d = PH_CHECK_INIT;
        status  = ST_WORKING;
      end
      ACT_POLL: begin
        if (phase_q == PH_CHECK_INIT) begin
          if (init_pin_i) begin
            phase_d = PH_FAILED;
            status  = ST_INIT_NOT_LOW;
          end else begin
            prog_d  = 1'b1;
            count_d = '0;
            phase_d = PH_WAIT_INIT;
            status  = ST_WORKING;
          end
        end else if (phase_q == PH_WAIT_INIT) begin
          status = ST_WORKING;
          if (init_pin_i) begin
            phase_d = PH_LOADING;
          end else if (init_over) begin
            phase_d = PH_FAILED;
            status  = ST_INIT_NOT_HIGH;
          end else begin
            count_d = count_inc;
          end
        end else if (phase_q == PH_WAIT_DONE) begin
          if (done_pin_i) begin
            phase_d = PH_FINISHED;
            status  = ST_DONE;
          end else if (done_over) begin
            phase_d = PH_FAILED;
            status  = ST_DONE_TIMEOUT;
          end else begin
            count_d   = count_inc;
            status    = ST_WORKING;
            clk_pulse = 1'b1;
          end
        end
      end
      ACT_DATA: begin
        if (phase_q == PH_LOADING) begin
          if (!done_pin_i && !init_pin_i) begin
            phase_d = PH_FAILED;
            status  = ST_CONFIG_ERROR;
          end else begin
            is_byte   = 1'b1;
            status    = ST_WORKING;
            clk_pulse = 1'b1;
            data_d    = data_byte_i[ByteWidth-1];
          end
        end
      end
      ACT_END: begin
        if (phase_q == PH_LOADING) begin
          if (done_pin_i) begin
            phase_d = PH_FINISHED;
            count_d = '0;
            status  = ST_DONE;
          end else if (done_over) begin
            phase_d = PH_FAILED;
            count_d = '0;
            status  = ST_DONE_TIMEOUT;
          end else begin
            phase_d   = PH_WAIT_DONE;
            count_d   = CountWidth'(1);
            status    = ST_WORKING;
            clk_pulse = 1'b1;
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  // command word
  always_comb begin
    cmd_o.is_byte  = is_byte;
    cmd_o.prog     = prog_d;
    cmd_o.data     = data_q;
    cmd_o.clk      = clk_pulse;
    cmd_o.status   = status;
    cmd_o.byte_val = data_byte_i;
  end

  // state, pin levels and limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      prog_q       <= 1'b1;
      data_q       <= 1'b0;
      init_limit_q <= InitLimitReset;
      done_limit_q <= DoneLimitReset;
    end else begin
      if (item_vld_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        prog_q  <= prog_d;
        data_q  <= data_d;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == RegInitLimit) begin
          init_limit_q <= cfg_data_i;
        end
        if (cfg_index_i == RegDoneLimit) begin
          done_limit_q <= cfg_data_i;
        end
      end
    end
  end

endmodule

@@ design/fscl_queue.sv @@
// ----------------------------------------------------------------------------
// fscl_queue: command queue between front and back
// Small first-in first-out buffer of command words with full and empty flags.
// ----------------------------------------------------------------------------
module fscl_queue import fscl_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  cmd_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign full_o   = (cnt_q == CntWidth'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end
  end

endmodule

@@ design/fscl_back.sv @@
// ----------------------------------------------------------------------------
// fscl_back: result generation
// Takes queued commands, shifts data bytes out LSB first one bit per cycle
// while pop allows, and holds each result in an output register until popped.
// ----------------------------------------------------------------------------
module fscl_back import fscl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  // queue head
  input  cmd_t    cmd_i,
  input  logic    cmd_empty_i,
  output logic    cmd_rd_o,
  // result side
  input  logic    pop_i,
  output logic    empty_o,
  output logic    prog_level_o,
  output logic    data_bit_o,
  output logic    clock_pulse_o,
  output status_e status_o,
  output logic    last_of_run_o
);

  logic [BitIdxWidth-1:0] bit_q;
  logic                   out_vld_q;
  logic                   prog_q, data_q, clk_q, last_q;
  status_e                status_q;
  logic                   load;
  logic                   is_last;

  // a new result enters when the output register is free or being drained
  assign load    = !cmd_empty_i && (!out_vld_q || pop_i);
  assign is_last = !cmd_i.is_byte || (bit_q == BitIdxWidth'(ByteWidth - 1));
  assign cmd_rd_o = load && is_last;

  assign empty_o       = !out_vld_q;
  assign prog_level_o  = prog_q;
  assign data_bit_o    = data_q;
  assign clock_pulse_o = clk_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  // bit counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        bit_q     <= is_last ? '0 : bit_q + BitIdxWidth'(1);
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      prog_q   <= cmd_i.prog;
      data_q   <= cmd_i.is_byte ? cmd_i.byte_val[bit_q] : cmd_i.data;
      clk_q    <= cmd_i.clk;
      status_q <= cmd_i.status;
      last_q   <= is_last;
    end
  end

endmodule

@@ design/fpga_serial_config_loader.sv @@
// ----------------------------------------------------------------------------
// fpga_serial_config_loader: slave-serial configuration sequencer
// Drives the program, data and clock pins of a device under configuration
// and reports the progress of the sequence as a stream of results.
// ----------------------------------------------------------------------------
// Every item is taken while full is low and gives one result, except an
// accepted data byte, which gives eight results, one per bit, LSB first. The
// result side delivers one result per cycle while pop is high, and the back
// part shifts each data byte out bit by bit; other items go at one per cycle
// unless full or pop holds them. A short command queue sits between the part
// that tracks the sequence and the part that shifts bits out, and full stays
// high while that queue holds QueueDepth commands. Limit registers may be
// written at any time the block is idle; the write port is always ready.
module fpga_serial_config_loader import fscl_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item input
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action_i,
  input  logic [ByteWidth-1:0]  data_byte_i,
  input  logic                  done_pin_i,
  input  logic                  init_pin_i,
  // result output
  output logic                  empty,
  input  logic                  pop,
  output logic                  prog_level_o,
  output logic                  data_bit_o,
  output logic                  clock_pulse_o,
  output logic [2:0]            status_o,
  output logic                  last_of_run_o,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [LimitWidth-1:0] cfg_data_i
);

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    q_full;
  logic    q_empty;
  logic    q_rd;
  logic    item_vld;
  status_e status;

  assign item_vld    = push && !q_full;
  assign full        = q_full;
  assign cfg_ready_o = 1'b1;
  assign status_o    = status;

  // sequence tracking
  fscl_front #(
    .CountWidth (CountWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_vld_i  (item_vld),
    .action_i    (action_e'(action_i)),
    .data_byte_i (data_byte_i),
    .done_pin_i  (done_pin_i),
    .init_pin_i  (init_pin_i),
    .cmd_o       (front_cmd)
  );

  // command queue
  fscl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_cmd_i (front_cmd),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_cmd_o (head_cmd),
    .empty_o  (q_empty)
  );

  // bit shifting and result register
  fscl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .cmd_empty_i   (q_empty),
    .cmd_rd_o      (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .prog_level_o  (prog_level_o),
    .data_bit_o    (data_bit_o),
    .clock_pulse_o (clock_pulse_o),
    .status_o      (status),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the slave-serial configuration loader
// Drives start, poll, data and end items with random pin levels and random
// gaps, keeps its own copy of the sequencer state to work out the pin levels
// and status that each item should give, and compares every popped result
// with the oldest one still due. Limit registers are changed between runs.
// ----------------------------------------------------------------------------
module tb;
  import fscl_pkg::*;

  localparam int MaxReports = 40;

  // sequencer phases as tracked on the bench side
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CHECK_INIT,
    SEQ_WAIT_INIT,
    SEQ_LOADING,
    SEQ_WAIT_DONE,
    SEQ_FINISHED,
    SEQ_FAILED
  } seq_phase_e;

  typedef struct packed {
    logic    prog;
    logic    data;
    logic    pulse;
    status_e status;
    logic    last;
  } pin_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [1:0]            action_i;
  logic [ByteWidth-1:0]  data_byte_i;
  logic                  done_pin_i;
  logic                  init_pin_i;
  logic                  empty;
  logic                  pop;
  logic                  prog_level_o;
  logic                  data_bit_o;
  logic                  clock_pulse_o;
  logic [2:0]            status_o;
  logic                  last_of_run_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [LimitWidth-1:0] cfg_data_i;

  // predicted sequencer state and limits
  seq_phase_e              seq_phase;
  logic [CountWidthDef-1:0] poll_cnt;
  logic                    prog_lvl;
  logic                    data_lvl;
  logic [LimitWidth-1:0]   init_limit;
  logic [LimitWidth-1:0]   done_limit;

  pin_result_t due_pins[$];
  int          mismatch_count;
  int          items_sent;
  int          rx_hold_req;
  bit          tx_idle_on;
  bit          rx_idle_on;

  fpga_serial_config_loader u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .done_pin_i    (done_pin_i),
    .init_pin_i    (init_pin_i),
    .empty         (empty),
    .pop           (pop),
    .prog_level_o  (prog_level_o),
    .data_bit_o    (data_bit_o),
    .clock_pulse_o (clock_pulse_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic void note_result(input logic pulse, input status_e st, input logic last);
    due_pins.push_back('{prog_lvl, data_lvl, pulse, st, last});
  endfunction

  // poll counter saturates at its top value
  function automatic void bump_count();
    if (poll_cnt != '1) poll_cnt = poll_cnt + 1'b1;
  endfunction

  // one step of the wait for done
  function automatic status_e done_wait_step(input logic done_v);
    if (done_v) begin
      seq_phase = SEQ_FINISHED;
      return ST_DONE;
    end
    if (poll_cnt > done_limit) begin
      seq_phase = SEQ_FAILED;
      return ST_DONE_TIMEOUT;
    end
    bump_count();
    return ST_WORKING;
  endfunction

  task automatic advance_sequence(input action_e act, input logic [7:0] data_v,
                                  input logic done_v, input logic init_v);
    status_e st;
    logic    pulse;
    st = ST_IGNORED;
    pulse = 1'b0;
    case (act)
      ACT_START: begin
        prog_lvl = 1'b0;
        poll_cnt = '0;
        seq_phase = SEQ_CHECK_INIT;
        st = ST_WORKING;
      end
      ACT_POLL: begin
        if (seq_phase == SEQ_CHECK_INIT) begin
          if (init_v) begin
            seq_phase = SEQ_FAILED;
            st = ST_INIT_NOT_LOW;
          end else begin
            prog_lvl = 1'b1;
            poll_cnt = '0;
            seq_phase = SEQ_WAIT_INIT;
            st = ST_WORKING;
          end
        end else if (seq_phase == SEQ_WAIT_INIT) begin
          st = ST_WORKING;
          if (init_v) begin
            seq_phase = SEQ_LOADING;
          end else if (poll_cnt > init_limit) begin
            seq_phase = SEQ_FAILED;
            st = ST_INIT_NOT_HIGH;
          end else begin
            bump_count();
          end
        end else if (seq_phase == SEQ_WAIT_DONE) begin
          st = done_wait_step(done_v);
          pulse = (st == ST_WORKING);
        end
      end
      ACT_DATA: begin
        if (seq_phase == SEQ_LOADING) begin
          if (!done_v && !init_v) begin
            seq_phase = SEQ_FAILED;
            st = ST_CONFIG_ERROR;
          end else begin
            // lsb first, one clocked bit per result
            for (int k = 0; k < 8; k++) begin
              data_lvl = data_v[k];
              note_result(1'b1, ST_WORKING, k == 7);
            end
            return;
          end
        end
      end
      ACT_END: begin
        if (seq_phase == SEQ_LOADING) begin
          seq_phase = SEQ_WAIT_DONE;
          poll_cnt = '0;
          st = done_wait_step(done_v);
          pulse = (st == ST_WORKING);
        end
      end
    endcase
    note_result(pulse, st, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
    if (want !== got) begin
      // keep the log short on a badly broken design
      if (mismatch_count < MaxReports)
        $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void compare_pins(input pin_result_t got);
    pin_result_t want;
    if (due_pins.size() == 0) begin
      if (mismatch_count < MaxReports)
        $error("result popped with nothing due: status %0d", got.status);
      mismatch_count++;
      return;
    end
    want = due_pins.pop_front();
    compare_field("prog_level", 3'(want.prog), 3'(got.prog));
    compare_field("data_bit", 3'(want.data), 3'(got.data));
    compare_field("clock_pulse", 3'(want.pulse), 3'(got.pulse));
    compare_field("status", want.status, got.status);
    compare_field("last_of_run", 3'(want.last), 3'(got.last));
  endfunction

  // result sink: random stalls, long hold-offs on request, checks at the
  // falling edge after the pop so the matching prediction is already queued
  initial begin : result_sink
    pin_result_t got;
    bit          have;
    int          stall;
    have = 1'b0;
    stall = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (have) begin
        compare_pins(got);
        have = 1'b0;
      end
      if (rx_hold_req > 0) begin
        pop <= 1'b0;
        rx_hold_req--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && pop && empty === 1'b0) begin
        got.prog = prog_level_o;
        got.data = data_bit_o;
        got.pulse = clock_pulse_o;
        got.status = status_e'(status_o);
        got.last = last_of_run_o;
        have = 1'b1;
        stall = idle_len(rx_idle_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic send_item(input action_e act, input logic [7:0] data_v,
                           input logic done_v, input logic init_v);
    int gap;
    @(negedge clk_i);
    push <= 1'b1;
    action_i <= act;
    data_byte_i <= data_v;
    done_pin_i <= done_v;
    init_pin_i <= init_v;
    do @(posedge clk_i); while (full !== 1'b0);
    advance_sequence(act, data_v, done_v, init_v);
    items_sent++;
    gap = idle_len(tx_idle_on);
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // sender holds back until every due result has been popped
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (due_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic idx, input logic [LimitWidth-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == RegInitLimit) init_limit = value;
    else done_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // each phase, the init-not-low and config-error failures, hand-picked pins, reset limits
  task automatic test_directed_sequence();
    // nothing but start is valid while idle
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_DATA, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_END, 8'h00, 1'b1, 1'b1);
    // init already high at the check
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA, 8'h12, 1'b1, 1'b1);
    // full load, done high at once
    send_item(ACT_START, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_DATA, 8'h3C, 1'b1, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA, 8'hFF, 1'b1, 1'b0);
    send_item(ACT_DATA, 8'h00, 1'b0, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b1, 1'b1);
    send_item(ACT_END, 8'h00, 1'b1, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b1, 1'b1);
    // restart while loading, then done after clocking
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_START, 8'hA5, 1'b1, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA, 8'hA5, 1'b1, 1'b1);
    send_item(ACT_END, 8'h00, 1'b0, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b1, 1'b0);
    // done and init both low on a byte
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA, 8'h81, 1'b0, 1'b0);
  endtask

  // zero limits, then limits of 16'hFFFE on a long init wait
  task automatic test_limit_extremes();
    wait_drained();
    write_limit(RegInitLimit, '0);
    write_limit(RegDoneLimit, '0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_DATA, 8'hC3, 1'b1, 1'b1);
    send_item(ACT_END, 8'h00, 1'b0, 1'b1);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);

    wait_drained();
    write_limit(RegInitLimit, 16'hFFFE);
    write_limit(RegDoneLimit, 16'hFFFE);
    // back-to-back polls at full rate
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    repeat (64) send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    send_item(ACT_END, 8'h00, 1'b0, 1'b1);
    repeat (20) send_item(ACT_POLL, 8'h00, 1'b0, 1'($urandom_range(0, 1)));
    send_item(ACT_POLL, 8'h00, 1'b1, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // sink held off while bytes keep coming, so the input stalls
  task automatic test_fill_and_drain();
    wait_drained();
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b0);
    send_item(ACT_POLL, 8'h00, 1'b0, 1'b1);
    tx_idle_on = 1'b0;
    rx_hold_req = 200;
    repeat (12) send_item(ACT_DATA, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    send_item(ACT_END, 8'h00, 1'b1, 1'b0);
    tx_idle_on = 1'b1;
    wait_drained();
  endtask

  // occasional stray item in the middle of a sequence
  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0)
      send_item(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // one well-formed load with random content and random wait lengths
  task automatic run_load_sequence();
    int         n;
    logic [1:0] pins;
    maybe_noise();
    send_item(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    maybe_noise();
    send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 9) == 0);
    n = $urandom_range(0, 14);
    repeat (n) begin
      maybe_noise();
      send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    end
    send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    n = $urandom_range(1, 8);
    repeat (n) begin
      maybe_noise();
      // done and init both low now and then
      pins = ($urandom_range(0, 11) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
      send_item(ACT_DATA, 8'($urandom_range(0, 255)), pins[1], pins[0]);
    end
    send_item(ACT_END, 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
              1'($urandom_range(0, 1)));
    n = $urandom_range(0, 14);
    repeat (n) begin
      maybe_noise();
      send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
    send_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [LimitWidth-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFE;
    return LimitWidth'($urandom_range(1, 12));
  endfunction

  // random loads under changing limits
  task automatic test_random_sequences();
    int first;
    first = items_sent;
    while (items_sent - first < 400) begin
      wait_drained();
      if ($urandom_range(0, 1)) begin
        write_limit(RegInitLimit, pick_limit());
        write_limit(RegDoneLimit, pick_limit());
      end else begin
        write_limit(RegDoneLimit, pick_limit());
        write_limit(RegInitLimit, pick_limit());
      end
      repeat (3) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) rx_hold_req = $urandom_range(20, 120);
        run_load_sequence();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni = 1'b0;
    push = 1'b0;
    action_i = ACT_START;
    data_byte_i = '0;
    done_pin_i = 1'b0;
    init_pin_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegInitLimit;
    cfg_data_i = '0;
    mismatch_count = 0;
    items_sent = 0;
    rx_hold_req = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // state after reset
    seq_phase = SEQ_IDLE;
    poll_cnt = '0;
    prog_lvl = 1'b1;
    data_lvl = 1'b0;
    init_limit = InitLimitReset;
    done_limit = DoneLimitReset;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_sequence();
    test_limit_extremes();
    test_fill_and_drain();
    test_random_sequences();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
